[hdl/klt_pkg.sv]
package klt_pkg;

    localparam int KEY_COUNT = 12;
    localparam int KEY_W     = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

    localparam int LED_W       = 4;
    localparam int BATCH_W     = 24;
    localparam int GREEN_BASE  = 12;
    localparam int NODE_W      = 7;
    localparam int MODES_W     = 24;
    localparam int FRAME_ID_W  = 11;
    localparam int TARGET_W    = 10;
    localparam int CODE_W      = 10;

    localparam logic [FRAME_ID_W-1:0] ID_PDO_IN  = 11'h180;
    localparam logic [TARGET_W-1:0]   ID_PDO_OUT = 10'h200;
    localparam logic [CODE_W-1:0]     BATCH_CODE = 10'd1000;
    localparam logic [NODE_W-1:0]     NODE_RESET = 7'h15;
    localparam logic [LED_W-1:0]      LED_MAX    = 4'd15;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_FRAME    = 3'd0,
        OP_READ_KEY = 3'd1,
        OP_UNLOCK   = 3'd2,
        OP_SET_LED  = 3'd3,
        OP_BATCH    = 3'd4,
        OP_READ_LED = 3'd5
    } t_opcode;

    typedef enum logic [1:0] {
        MODE_MOMENTARY = 2'd0,
        MODE_LATCH     = 2'd1,
        MODE_TOGGLE    = 2'd2,
        MODE_LATCH_ALT = 2'd3
    } t_key_mode;

    typedef enum logic [1:0] {
        KIND_KEY   = 2'd0,
        KIND_LED   = 2'd1,
        KIND_BATCH = 2'd2
    } t_result_kind;

    typedef enum logic [0:0] {
        CFG_NODE_ID     = 1'b0,
        CFG_LATCH_MODES = 1'b1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        CMD_FRAME,
        CMD_READ_KEY,
        CMD_UNLOCK,
        CMD_SET_LED,
        CMD_BATCH,
        CMD_READ_LED
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind              kind;
        logic                   idx_ok;
        logic [KEY_W-1:0]       idx;
        logic [KEY_COUNT-1:0]   keys;
        logic [LED_W-1:0]       led;
    } t_cmd;

    typedef struct packed {
        logic [NODE_W-1:0]  node_id;
        logic [MODES_W-1:0] latch_modes;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

[hdl/klt_if.sv]
interface klt_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [10:0] frame_id;
    logic [15:0] key_bits;
    logic [3:0]  key_index;
    logic [9:0]  led_code;

    modport source (output valid, opcode, frame_id, key_bits, key_index, led_code,
                    input ready);
    modport sink   (input valid, opcode, frame_id, key_bits, key_index, led_code,
                    output ready);
endinterface

interface klt_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic        key_value;
    logic [3:0]  led_value;
    logic [23:0] led_batch;
    logic [9:0]  batch_target;

    modport source (output valid, result_kind, key_value, led_value, led_batch,
                    batch_target, input ready);
    modport sink   (input valid, result_kind, key_value, led_value, led_batch,
                    batch_target, output ready);
endinterface

interface klt_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [23:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hdl/klt_front.sv]
module klt_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    klt_in_if.sink              i_in,
    klt_cfg_if.sink             i_cfg,
    input  klt_pkg::t_q_stat    i_q_stat,
    output logic                o_push,
    output klt_pkg::t_cmd       o_cmd,
    output klt_pkg::t_cfg       o_cfg
);

    klt_pkg::t_cfg r_cfg;
    klt_pkg::t_cfg n_cfg;
    logic          w_keep;
    logic          w_idx_ok;
    logic          w_frame_hit;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !i_q_stat.full;
    assign o_cfg       = r_cfg;
    assign o_push      = i_in.valid && i_in.ready && w_keep;

    assign w_idx_ok    = {1'b0, i_in.key_index} < 5'(klt_pkg::KEY_COUNT);
    assign w_frame_hit = i_in.frame_id ==
                         (klt_pkg::ID_PDO_IN + klt_pkg::FRAME_ID_W'(r_cfg.node_id));

    always_comb begin
        o_cmd.kind   = klt_pkg::CMD_FRAME;
        o_cmd.idx_ok = w_idx_ok;
        o_cmd.idx    = i_in.key_index[klt_pkg::KEY_W-1:0];
        o_cmd.keys   = i_in.key_bits[klt_pkg::KEY_COUNT-1:0];
        o_cmd.led    = (i_in.led_code > klt_pkg::CODE_W'(klt_pkg::LED_MAX)) ?
                       klt_pkg::LED_MAX : i_in.led_code[klt_pkg::LED_W-1:0];
        w_keep       = 1'b0;
        unique case (klt_pkg::t_opcode'(i_in.opcode))
            klt_pkg::OP_FRAME: begin
                o_cmd.kind = klt_pkg::CMD_FRAME;
                w_keep     = w_frame_hit;
            end
            klt_pkg::OP_READ_KEY: begin
                o_cmd.kind = klt_pkg::CMD_READ_KEY;
                w_keep     = 1'b1;
            end
            klt_pkg::OP_UNLOCK: begin
                o_cmd.kind = klt_pkg::CMD_UNLOCK;
                w_keep     = w_idx_ok;
            end
            klt_pkg::OP_SET_LED: begin
                if (i_in.key_index == '0 && i_in.led_code == klt_pkg::BATCH_CODE) begin
                    o_cmd.kind = klt_pkg::CMD_BATCH;
                    w_keep     = 1'b1;
                end else begin
                    o_cmd.kind = klt_pkg::CMD_SET_LED;
                    w_keep     = w_idx_ok;
                end
            end
            klt_pkg::OP_BATCH: begin
                o_cmd.kind = klt_pkg::CMD_BATCH;
                w_keep     = 1'b1;
            end
            klt_pkg::OP_READ_LED: begin
                o_cmd.kind = klt_pkg::CMD_READ_LED;
                w_keep     = 1'b1;
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid && i_cfg.ready) begin
            unique case (klt_pkg::t_cfg_reg'(i_cfg.index))
                klt_pkg::CFG_NODE_ID:     n_cfg.node_id     = i_cfg.data[klt_pkg::NODE_W-1:0];
                klt_pkg::CFG_LATCH_MODES: n_cfg.latch_modes = i_cfg.data[klt_pkg::MODES_W-1:0];
                default:                  n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.node_id     <= klt_pkg::NODE_RESET;
            r_cfg.latch_modes <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

[hdl/klt_queue.sv]
module klt_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  klt_pkg::t_cmd       i_cmd,
    input  logic                i_pop,
    output klt_pkg::t_cmd       o_cmd,
    output klt_pkg::t_q_stat    o_stat
);

    klt_pkg::t_cmd                 r_mem [klt_pkg::Q_DEPTH];
    logic [klt_pkg::Q_PTR_W-1:0]   r_wr_ptr;
    logic [klt_pkg::Q_PTR_W-1:0]   r_rd_ptr;
    logic [klt_pkg::Q_CNT_W-1:0]   r_count;
    logic [klt_pkg::Q_PTR_W-1:0]   n_wr_ptr;
    logic [klt_pkg::Q_PTR_W-1:0]   n_rd_ptr;
    logic [klt_pkg::Q_CNT_W-1:0]   n_count;

    localparam logic [klt_pkg::Q_PTR_W-1:0] PTR_LAST = klt_pkg::Q_PTR_W'(klt_pkg::Q_DEPTH - 1);

    assign o_cmd        = r_mem[r_rd_ptr];
    assign o_stat.full  = r_count == klt_pkg::Q_CNT_W'(klt_pkg::Q_DEPTH);
    assign o_stat.empty = r_count == '0;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        priority if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_stat.full && !i_pop))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_stat.empty))
        else $error("queue pop while empty");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= klt_pkg::Q_CNT_W'(klt_pkg::Q_DEPTH))
        else $error("queue count out of range");
`endif

endmodule

[hdl/klt_back.sv]
module klt_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  klt_pkg::t_cfg       i_cfg,
    input  klt_pkg::t_q_stat    i_q_stat,
    input  klt_pkg::t_cmd       i_cmd,
    output logic                o_pop,
    klt_out_if.source           o_out
);

    logic [klt_pkg::KEY_COUNT-1:0] r_rep;
    logic [klt_pkg::KEY_COUNT-1:0] r_raw;
    logic [klt_pkg::KEY_COUNT-1:0] r_armed;
    logic [klt_pkg::LED_W-1:0]     r_led [klt_pkg::KEY_COUNT];
    logic [klt_pkg::KEY_COUNT-1:0] n_rep;
    logic [klt_pkg::KEY_COUNT-1:0] n_raw;
    logic [klt_pkg::KEY_COUNT-1:0] n_armed;
    logic [klt_pkg::LED_W-1:0]     n_led [klt_pkg::KEY_COUNT];

    logic                          r_out_valid;
    logic [1:0]                    r_kind;
    logic                          r_key_value;
    logic [klt_pkg::LED_W-1:0]     r_led_value;
    logic [klt_pkg::BATCH_W-1:0]   r_batch;
    logic [klt_pkg::TARGET_W-1:0]  r_target;

    logic                          w_emit;
    logic [1:0]                    w_kind;
    logic                          w_key_value;
    logic [klt_pkg::LED_W-1:0]     w_led_value;
    logic [klt_pkg::BATCH_W-1:0]   w_batch;
    logic [klt_pkg::TARGET_W-1:0]  w_target;
    logic [klt_pkg::BATCH_W-1:0]   w_word;
    klt_pkg::t_key_mode            w_mode;

    assign o_pop = !i_q_stat.empty && (!r_out_valid || o_out.ready);

    assign o_out.valid        = r_out_valid;
    assign o_out.result_kind  = r_kind;
    assign o_out.key_value    = r_key_value;
    assign o_out.led_value    = r_led_value;
    assign o_out.led_batch    = r_batch;
    assign o_out.batch_target = r_target;

    assign w_mode = klt_pkg::t_key_mode'(i_cfg.latch_modes[{i_cmd.idx, 1'b0} +: 2]);

    always_comb begin
        w_word = '0;
        for (int k = 0; k < klt_pkg::KEY_COUNT; k++) begin
            w_word[k]                      = r_led[k][0];
            w_word[klt_pkg::GREEN_BASE + k] = r_led[k][2];
        end
    end

    always_comb begin
        klt_pkg::t_key_mode m;
        n_rep       = r_rep;
        n_raw       = r_raw;
        n_armed     = r_armed;
        n_led       = r_led;
        w_emit      = 1'b0;
        w_kind      = klt_pkg::KIND_KEY;
        w_key_value = 1'b0;
        w_led_value = '0;
        w_batch     = '0;
        w_target    = '0;
        m           = klt_pkg::MODE_MOMENTARY;
        if (o_pop) begin
            unique case (i_cmd.kind)
                klt_pkg::CMD_FRAME: begin
                    n_raw = i_cmd.keys;
                    for (int k = 0; k < klt_pkg::KEY_COUNT; k++) begin
                        m = klt_pkg::t_key_mode'(i_cfg.latch_modes[2*k +: 2]);
                        if (i_cmd.keys[k]) begin
                            if (m != klt_pkg::MODE_TOGGLE) begin
                                n_rep[k] = 1'b1;
                            end else if (!r_armed[k]) begin
                                n_armed[k] = 1'b1;
                                n_rep[k]   = !r_rep[k];
                            end
                        end else begin
                            if (m == klt_pkg::MODE_MOMENTARY) begin
                                n_rep[k] = 1'b0;
                            end
                            n_armed[k] = 1'b0;
                        end
                    end
                end
                klt_pkg::CMD_READ_KEY: begin
                    w_emit = 1'b1;
                    w_kind = klt_pkg::KIND_KEY;
                    if (i_cmd.idx_ok) begin
                        w_key_value = r_rep[i_cmd.idx];
                        if (w_mode == klt_pkg::MODE_LATCH ||
                            w_mode == klt_pkg::MODE_LATCH_ALT) begin
                            n_rep[i_cmd.idx] = r_raw[i_cmd.idx];
                        end
                    end
                end
                klt_pkg::CMD_UNLOCK: begin
                    n_rep[i_cmd.idx] = r_raw[i_cmd.idx];
                end
                klt_pkg::CMD_SET_LED: begin
                    n_led[i_cmd.idx] = i_cmd.led;
                end
                klt_pkg::CMD_BATCH: begin
                    w_emit   = 1'b1;
                    w_kind   = klt_pkg::KIND_BATCH;
                    w_batch  = w_word;
                    w_target = klt_pkg::ID_PDO_OUT + klt_pkg::TARGET_W'(i_cfg.node_id);
                end
                klt_pkg::CMD_READ_LED: begin
                    w_emit = 1'b1;
                    w_kind = klt_pkg::KIND_LED;
                    if (i_cmd.idx_ok) begin
                        w_led_value = r_led[i_cmd.idx];
                    end
                end
                default: begin
                    w_emit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rep       <= '0;
            r_raw       <= '0;
            r_armed     <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < klt_pkg::KEY_COUNT; k++) begin
                r_led[k] <= '0;
            end
        end else begin
            r_rep   <= n_rep;
            r_raw   <= n_raw;
            r_armed <= n_armed;
            r_led   <= n_led;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_kind      <= w_kind;
            r_key_value <= w_key_value;
            r_led_value <= w_led_value;
            r_batch     <= w_batch;
            r_target    <= w_target;
        end
    end

`ifndef ASSERT_OFF
    a_no_pop_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !o_pop)
        else $error("command taken while result stalled");
    a_key_fields_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == klt_pkg::KIND_KEY) |->
        (r_led_value == '0 && r_batch == '0 && r_target == '0))
        else $error("key result carries stray fields");
    a_batch_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == klt_pkg::KIND_BATCH) |->
        (r_target == klt_pkg::ID_PDO_OUT + klt_pkg::TARGET_W'(i_cfg.node_id)))
        else $error("batch target does not match node");
`endif

endmodule

[hdl/keypad_latch_toggle_led_table.sv]
// Channel   Dir  Beat payload
// i_in      in   opcode, frame_id, key_bits, key_index, led_code
// o_out     out  result_kind, key_value, led_value, led_batch, batch_target
// i_cfg     in   index (0 node_id, 1 latch_modes), data
//
// One beat per cycle while o_out is ready; commands are queued, results registered.
// Front decodes into a two-entry command queue; back pops one per unstalled cycle.
// Output register stalls the back only; the queue absorbs it until full.
// i_rst_n synchronous: node_id 0x15, modes, key state and LED table cleared.
// The front drops foreign frames, bad opcodes and bad-index unlock/set-LED items.
module keypad_latch_toggle_led_table (
    input  logic       i_clk,
    input  logic       i_rst_n,
    klt_in_if.sink     i_in,
    klt_cfg_if.sink    i_cfg,
    klt_out_if.source  o_out
);

    logic              w_push;
    logic              w_pop;
    klt_pkg::t_cmd     w_cmd_in;
    klt_pkg::t_cmd     w_cmd_out;
    klt_pkg::t_q_stat  w_q_stat;
    klt_pkg::t_cfg     w_cfg;

    klt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (i_cfg),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_cmd    (w_cmd_in),
        .o_cfg    (w_cfg)
    );

    klt_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_cmd_in),
        .i_pop    (w_pop),
        .o_cmd    (w_cmd_out),
        .o_stat   (w_q_stat)
    );

    klt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_q_stat (w_q_stat),
        .i_cmd    (w_cmd_out),
        .o_pop    (w_pop),
        .o_out    (o_out)
    );

endmodule
